### rtl/core/dbsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsq_pkg
// Shared types, codes and field layouts for the display buffer slot queue.
// ----------------------------------------------------------------------------
package dbsq_pkg;

	localparam int DEF_MAX_ENTRIES = 16;

	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;
	localparam int DIM_W    = 16;
	localparam int XFORM_W  = 8;
	localparam int CROP_W   = 16;
	localparam int ESTATE_W = 2;

	localparam int IN_W         = SLOT_W + 2 * DIM_W + XFORM_W + 4 * CROP_W;
	localparam int OUT_W        = IN_W + 1;
	localparam int TDATA_W      = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_WAKE_BIT = OUT_W - 1;

	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUEUE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NONE    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_WRONG   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;

	localparam logic [ESTATE_W-1:0] ES_FREE     = 2'd0;
	localparam logic [ESTATE_W-1:0] ES_DEQUEUED = 2'd1;
	localparam logic [ESTATE_W-1:0] ES_QUEUED   = 2'd2;
	localparam logic [ESTATE_W-1:0] ES_ACQUIRED = 2'd3;

	typedef struct packed {
		logic signed [CROP_W-1:0] crop_bottom;
		logic signed [CROP_W-1:0] crop_right;
		logic signed [CROP_W-1:0] crop_top;
		logic signed [CROP_W-1:0] crop_left;
		logic [XFORM_W-1:0]       transform;
		logic [DIM_W-1:0]         height;
		logic [DIM_W-1:0]         width;
		logic [SLOT_W-1:0]        slot;
	} in_item_t;

	typedef struct packed {
		logic                     wake;
		logic signed [CROP_W-1:0] crop_bottom;
		logic signed [CROP_W-1:0] crop_right;
		logic signed [CROP_W-1:0] crop_top;
		logic signed [CROP_W-1:0] crop_left;
		logic [XFORM_W-1:0]       transform;
		logic [DIM_W-1:0]         height;
		logic [DIM_W-1:0]         width;
		logic [SLOT_W-1:0]        slot;
	} result_t;

	typedef struct packed {
		logic signed [CROP_W-1:0] crop_bottom;
		logic signed [CROP_W-1:0] crop_right;
		logic signed [CROP_W-1:0] crop_top;
		logic signed [CROP_W-1:0] crop_left;
		logic [XFORM_W-1:0]       transform;
		logic [DIM_W-1:0]         height;
		logic [DIM_W-1:0]         width;
		logic [ESTATE_W-1:0]      state;
		logic [SLOT_W-1:0]        slot;
	} entry_t;

endpackage

### rtl/core/display_buffer_slot_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_buffer_slot_queue
// Table of display buffer entries in insertion order, driven by six commands.
// ----------------------------------------------------------------------------
// One command is taken at a time and answered with exactly one result. An add
// writes its new entry and loads the output register without walking the table.
// The other commands walk the table from its first entry through a single RAM
// read port and one shared comparator, reading and then comparing each entry
// visited. A new command is accepted while the previous result still waits in
// the output register.
module display_buffer_slot_queue #(
	parameter int MAX_ENTRIES = dbsq_pkg::DEF_MAX_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// slot, width, height, transform, crop_left, crop_top, crop_right,
	// crop_bottom, zero fill
	input  logic [dbsq_pkg::TDATA_W-1:0] s_tdata,
	// cmd
	input  logic [dbsq_pkg::CMD_W-1:0]   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_slot, out_width, out_height, out_transform, out_crop_left,
	// out_crop_top, out_crop_right, out_crop_bottom, wake, zero fill
	output logic [dbsq_pkg::TDATA_W-1:0] m_tdata,
	// status
	output logic [dbsq_pkg::STATUS_W-1:0] m_tuser
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int EW = $bits(dbsq_pkg::entry_t);
	localparam int KW = dbsq_pkg::ESTATE_W + 2 * dbsq_pkg::DIM_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                     state_q;
	logic [dbsq_pkg::CMD_W-1:0]     cmd_q;
	dbsq_pkg::in_item_t             req_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  idx_q;
	logic [dbsq_pkg::STATUS_W-1:0]  stat_q;
	dbsq_pkg::result_t              res_q;
	logic                           m_tvalid_q;
	logic [dbsq_pkg::STATUS_W-1:0]  m_stat_q;
	dbsq_pkg::result_t              m_res_q;

	logic                           wr_en;
	logic [IW-1:0]                  wr_addr;
	dbsq_pkg::entry_t               wr_ent;
	logic [EW-1:0]                  rd_raw;
	dbsq_pkg::entry_t               rd_ent;
	logic [KW-1:0]                  cmp_a;
	logic [KW-1:0]                  cmp_b;
	logic                           hit;
	logic                           ent_ok;
	logic                           full;
	logic                           out_free;

	assign rd_ent   = dbsq_pkg::entry_t'(rd_raw);
	assign full     = (count_q == CW'(MAX_ENTRIES));
	assign out_free = !m_tvalid_q || m_tready;

	// Shared key comparator used by every table scan.
	always_comb begin
		case (cmd_q)
			dbsq_pkg::CMD_DEQUEUE: begin
				cmp_a = {rd_ent.state, rd_ent.height, rd_ent.width};
				cmp_b = {dbsq_pkg::ES_FREE, req_q.height, req_q.width};
			end
			dbsq_pkg::CMD_ACQUIRE: begin
				cmp_a = {rd_ent.state, {(2 * dbsq_pkg::DIM_W){1'b0}}};
				cmp_b = {dbsq_pkg::ES_QUEUED, {(2 * dbsq_pkg::DIM_W){1'b0}}};
			end
			default: begin
				cmp_a = {{(KW - dbsq_pkg::SLOT_W){1'b0}}, rd_ent.slot};
				cmp_b = {{(KW - dbsq_pkg::SLOT_W){1'b0}}, req_q.slot};
			end
		endcase
		hit = (cmp_a == cmp_b);
		ent_ok = (rd_ent.state == ((cmd_q == dbsq_pkg::CMD_RELEASE) ?
			dbsq_pkg::ES_ACQUIRED : dbsq_pkg::ES_DEQUEUED));
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_ent  = rd_ent;
		case (state_q)
			S_START: begin
				if (cmd_q == dbsq_pkg::CMD_ADD && !full) begin
					wr_en        = 1'b1;
					wr_addr      = count_q[IW-1:0];
					wr_ent       = '0;
					wr_ent.slot  = req_q.slot;
					wr_ent.width = req_q.width;
					wr_ent.height = req_q.height;
					wr_ent.state = dbsq_pkg::ES_FREE;
				end
			end
			S_CMP: begin
				if (idx_q != count_q && hit) begin
					case (cmd_q)
						dbsq_pkg::CMD_DEQUEUE: begin
							wr_en        = 1'b1;
							wr_ent.state = dbsq_pkg::ES_DEQUEUED;
						end
						dbsq_pkg::CMD_ACQUIRE: begin
							wr_en        = 1'b1;
							wr_ent.state = dbsq_pkg::ES_ACQUIRED;
						end
						dbsq_pkg::CMD_QUEUE: begin
							wr_en              = ent_ok;
							wr_ent.state       = dbsq_pkg::ES_QUEUED;
							wr_ent.transform   = req_q.transform;
							wr_ent.crop_left   = req_q.crop_left;
							wr_ent.crop_top    = req_q.crop_top;
							wr_ent.crop_right  = req_q.crop_right;
							wr_ent.crop_bottom = req_q.crop_bottom;
						end
						dbsq_pkg::CMD_RELEASE: begin
							wr_en        = ent_ok;
							wr_ent.state = dbsq_pkg::ES_FREE;
						end
						default: begin
							wr_en = 1'b0;
						end
					endcase
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	dbsq_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_ent),
		.rd_addr(idx_q[IW-1:0]),
		.rd_data(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			cmd_q      <= dbsq_pkg::CMD_ADD;
			req_q      <= '0;
			stat_q     <= dbsq_pkg::STAT_OK;
			res_q      <= '0;
			m_stat_q   <= dbsq_pkg::STAT_OK;
			m_res_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q    <= s_tuser;
						req_q    <= dbsq_pkg::in_item_t'(s_tdata[dbsq_pkg::IN_W-1:0]);
						state_q  <= S_START;
					end
				end
				S_START: begin
					idx_q <= '0;
					res_q <= dbsq_pkg::result_t'({(cmd_q == dbsq_pkg::CMD_ADD && !full),
						{(dbsq_pkg::OUT_W - 1 - dbsq_pkg::SLOT_W){1'b0}}, req_q.slot});
					case (cmd_q)
						dbsq_pkg::CMD_ADD: begin
							if (full) begin
								stat_q <= dbsq_pkg::STAT_FULL;
							end else begin
								stat_q     <= dbsq_pkg::STAT_OK;
								count_q    <= count_q + CW'(1);
							end
							state_q <= S_DONE;
						end
						dbsq_pkg::CMD_DEQUEUE, dbsq_pkg::CMD_REQUEST, dbsq_pkg::CMD_QUEUE,
						dbsq_pkg::CMD_ACQUIRE, dbsq_pkg::CMD_RELEASE: begin
							stat_q  <= dbsq_pkg::STAT_WRONG;
							state_q <= S_RD;
						end
						default: begin
							stat_q  <= dbsq_pkg::STAT_WRONG;
							state_q <= S_DONE;
						end
					endcase
				end
				S_RD: begin
					if (idx_q == count_q) begin
						if (cmd_q == dbsq_pkg::CMD_DEQUEUE || cmd_q == dbsq_pkg::CMD_ACQUIRE) begin
							stat_q <= dbsq_pkg::STAT_NONE;
						end else begin
							stat_q <= dbsq_pkg::STAT_UNKNOWN;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						state_q <= S_DONE;
						case (cmd_q)
							dbsq_pkg::CMD_DEQUEUE: begin
								stat_q     <= dbsq_pkg::STAT_OK;
								res_q.slot <= rd_ent.slot;
							end
							dbsq_pkg::CMD_ACQUIRE: begin
								stat_q            <= dbsq_pkg::STAT_OK;
								res_q.slot        <= rd_ent.slot;
								res_q.width       <= rd_ent.width;
								res_q.height      <= rd_ent.height;
								res_q.transform   <= rd_ent.transform;
								res_q.crop_left   <= rd_ent.crop_left;
								res_q.crop_top    <= rd_ent.crop_top;
								res_q.crop_right  <= rd_ent.crop_right;
								res_q.crop_bottom <= rd_ent.crop_bottom;
							end
							dbsq_pkg::CMD_REQUEST: begin
								if (ent_ok) begin
									stat_q       <= dbsq_pkg::STAT_OK;
									res_q.slot   <= rd_ent.slot;
									res_q.width  <= rd_ent.width;
									res_q.height <= rd_ent.height;
								end
							end
							dbsq_pkg::CMD_QUEUE: begin
								if (ent_ok) begin
									stat_q <= dbsq_pkg::STAT_OK;
								end
							end
							dbsq_pkg::CMD_RELEASE: begin
								if (ent_ok) begin
									stat_q     <= dbsq_pkg::STAT_OK;
									res_q.wake <= 1'b1;
								end
							end
							default: begin
								stat_q <= dbsq_pkg::STAT_WRONG;
							end
						endcase
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_stat_q   <= stat_q;
						m_res_q    <= res_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_stat_q;
	assign m_tdata  = {{(dbsq_pkg::TDATA_W - dbsq_pkg::OUT_W){1'b0}}, m_res_q};

endmodule

### rtl/core/dbsq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dbsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### rtl/core/dbsq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsq_checker
// Port-level checks on the display buffer slot queue, bound to the top level.
// ----------------------------------------------------------------------------
module dbsq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dbsq_pkg::TDATA_W-1:0]  m_tdata,
	input logic [dbsq_pkg::STATUS_W-1:0] m_tuser
);

	logic s_fire;

	assign s_fire = s_tvalid && s_tready;

	// Only one command is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("input accepted while a command was in work");

	// A wake-up comes only with a successful add or release.
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[dbsq_pkg::OUT_WAKE_BIT]) |-> (m_tuser == dbsq_pkg::STAT_OK))
		else $error("wake reported with a failing status");

	// A failed command reports no size, transform or crop.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != dbsq_pkg::STAT_OK) |->
		(m_tdata[dbsq_pkg::OUT_WAKE_BIT:dbsq_pkg::SLOT_W] == '0))
		else $error("failed command carries result data");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= dbsq_pkg::STAT_FULL))
		else $error("undefined status code");

	// A stalled result transaction holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind display_buffer_slot_queue dbsq_checker u_dbsq_checker (.*);
